FILE: rtl/wvm_pkg.sv
package wvm_pkg;

    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_PLAY  = 2'd1,
        FUNC_STOP  = 2'd2,
        FUNC_TICK  = 2'd3
    } t_func;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RD1,
        ST_RD2,
        ST_MUL1,
        ST_MUL2,
        ST_ACC,
        ST_NEXT,
        ST_ROUND,
        ST_OUT
    } t_state;

    localparam int unsigned POS_W   = 21;
    localparam int unsigned LEN_W   = 13;
    localparam int unsigned STEP_W  = 16;
    localparam int unsigned GAIN_W  = 16;
    localparam int unsigned SMP_W   = 16;
    localparam int unsigned ADDR_W  = 12;
    localparam int unsigned ACC_SHIFT = 38;
    localparam int unsigned ACC_W   = 56;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    typedef struct packed {
        logic load_item;
        logic write_frame;
        logic play_commit;
        logic stop_commit;
        logic scan_start;
        logic scan_step;
        logic rd1;
        logic rd2;
        logic mul1;
        logic mul2;
        logic acc;
        logic voice_update;
        logic do_round;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] in_func;
        logic [1:0] func;
        logic       scan_done;
        logic       voice_hit;
    } t_status;

endpackage

FILE: rtl/wvm_ctrl.sv
module wvm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    input  wvm_pkg::t_status i_status,
    output wvm_pkg::t_cmd    o_cmd
);
    import wvm_pkg::*;

    t_state r_state, n_state;
    logic   r_valid, n_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_s_tvalid && (!r_valid || i_m_tready)) begin
                n_state = (i_status.in_func == FUNC_WRITE) ? ST_OUT : ST_SCAN;
            end
            ST_SCAN: begin
                if (i_status.scan_done) begin
                    n_state = (i_status.func == FUNC_TICK) ? ST_ROUND : ST_OUT;
                end else if (i_status.voice_hit && i_status.func == FUNC_TICK) begin
                    n_state = ST_RD1;
                end
            end
            ST_RD1:   n_state = ST_RD2;
            ST_RD2:   n_state = ST_MUL1;
            ST_MUL1:  n_state = ST_MUL2;
            ST_MUL2:  n_state = ST_ACC;
            ST_ACC:   n_state = ST_NEXT;
            ST_NEXT:  n_state = ST_SCAN;
            ST_ROUND: n_state = ST_OUT;
            ST_OUT:   n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_s_tready = 1'b0;
        n_valid = r_valid && !i_m_tready;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready = !r_valid || i_m_tready;
                o_cmd.load_item = i_s_tvalid && o_s_tready;
                o_cmd.write_frame = o_cmd.load_item && (i_status.in_func == FUNC_WRITE);
                o_cmd.scan_start = o_cmd.load_item;
            end
            ST_SCAN: begin
                o_cmd.scan_step = !i_status.scan_done &&
                                  !(i_status.voice_hit && i_status.func == FUNC_TICK);
                o_cmd.play_commit = i_status.scan_done && i_status.func == FUNC_PLAY;
                o_cmd.stop_commit = i_status.scan_done && i_status.func == FUNC_STOP;
            end
            ST_RD1:   o_cmd.rd1 = 1'b1;
            ST_RD2:   o_cmd.rd2 = 1'b1;
            ST_MUL1:  o_cmd.mul1 = 1'b1;
            ST_MUL2:  o_cmd.mul2 = 1'b1;
            ST_ACC:   o_cmd.acc = 1'b1;
            ST_NEXT:  o_cmd.voice_update = 1'b1;
            ST_ROUND: o_cmd.do_round = 1'b1;
            ST_OUT: begin
                o_cmd.out_load = 1'b1;
                n_valid = 1'b1;
            end
            default: ;
        endcase
    end

    assign o_m_tvalid = r_valid;
endmodule

FILE: rtl/wvm_datapath.sv
module wvm_datapath #(
    parameter int VOICES      = 16,
    parameter int FRAME_DEPTH = 4096
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [1:0]                   i_func,
    input  logic [wvm_pkg::ADDR_W-1:0]   i_address,
    input  logic [15:0]                  i_left,
    input  logic [15:0]                  i_right,
    input  logic [wvm_pkg::LEN_W-1:0]    i_length,
    input  logic                         i_loop,
    input  logic                         i_unique,
    input  logic [wvm_pkg::STEP_W-1:0]   i_step,
    input  logic [wvm_pkg::GAIN_W-1:0]   i_gain,
    input  wvm_pkg::t_cmd                i_cmd,
    output wvm_pkg::t_status             o_status,
    output logic [15:0]                  o_mixed,
    output logic                         o_right_side,
    output logic                         o_accepted,
    output logic [3:0]                   o_vidx
);
    import wvm_pkg::*;

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int FW = $clog2(FRAME_DEPTH);
    localparam logic signed [ACC_W-1:0] LIM = 56'sd32767 <<< ACC_SHIFT;

    logic [31:0] r_mem [FRAME_DEPTH];

    logic [VOICES-1:0]        r_active;
    logic [ADDR_W-1:0]        r_base [VOICES];
    logic [LEN_W-1:0]         r_len  [VOICES];
    logic [POS_W-1:0]         r_pos  [VOICES];
    logic [STEP_W-1:0]        r_stp  [VOICES];
    logic [GAIN_W-1:0]        r_gn   [VOICES];
    logic [VOICES-1:0]        r_lp;
    logic                     r_phase;

    logic [1:0]               r_func;
    logic [ADDR_W-1:0]        r_addr;
    logic [LEN_W-1:0]         r_ilen;
    logic                     r_iloop, r_iuniq;
    logic [STEP_W-1:0]        r_istep;
    logic [GAIN_W-1:0]        r_igain;

    logic [VW:0]              r_v;
    logic                     r_dup, r_freef, r_stopf;
    logic [VW-1:0]            r_free, r_stopv;

    logic [31:0]              r_rd;
    logic signed [SMP_W-1:0]  r_s1, r_s2;
    logic signed [25:0]       r_interp;
    logic [31:0]              r_gsq;
    logic signed [58:0]       r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [16:0]       r_round;

    logic [VW-1:0]            w_vi;
    logic                     w_act, w_hit;
    logic [POS_W-1:0]         w_pos;
    logic [POS_W-9:0]         w_idx;
    logic [FW-1:0]            w_a1, w_a2;
    logic signed [25:0]       w_s1x, w_s2x, w_fa, w_fb;

    assign w_vi  = r_v[VW-1:0];
    assign w_act = r_active[w_vi];
    assign w_hit = w_act && (r_base[w_vi] == r_addr);
    assign w_pos = r_pos[w_vi];
    assign w_idx = w_pos[POS_W-1:8];
    assign w_a1  = FW'({2'b0, r_base[w_vi]} + {1'b0, w_idx});
    assign w_a2  = FW'({2'b0, r_base[w_vi]} + {1'b0, w_idx} + 14'd1);

    assign w_s1x = {{(26-SMP_W){r_s1[SMP_W-1]}}, r_s1};
    assign w_s2x = {{(26-SMP_W){r_s2[SMP_W-1]}}, r_s2};
    assign w_fa  = $signed({17'b0, 9'd256 - {1'b0, w_pos[7:0]}});
    assign w_fb  = $signed({18'b0, w_pos[7:0]});

    assign o_status.in_func   = i_func;
    assign o_status.func      = r_func;
    assign o_status.scan_done = (r_v == (VW+1)'(VOICES));
    assign o_status.voice_hit = (r_func == FUNC_TICK) ? w_act : 1'b0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.write_frame) begin
            r_mem[FW'(i_address)] <= {i_right, i_left};
        end
        if (i_cmd.rd1) begin
            r_rd <= r_mem[w_a1];
        end
        if (i_cmd.rd2) begin
            r_rd <= r_mem[w_a2];
        end
    end

    logic [POS_W:0]  w_sum;
    logic [POS_W-1:0] w_npos;
    logic signed [ACC_W:0] w_accs;
    logic signed [ACC_W-1:0] w_mag;

    always_comb begin
        w_sum = {1'b0, w_pos} + (POS_W+1)'(r_stp[w_vi]);
        w_npos = r_phase ? (w_sum[POS_W] ? POS_MAX : w_sum[POS_W-1:0]) : w_pos;
        w_accs = (ACC_W+1)'(r_acc) + (ACC_W+1)'(r_prod);
        w_mag = r_acc[ACC_W-1] ? -r_acc : r_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            r_phase  <= 1'b0;
            r_v      <= '0;
        end else begin
            if (i_cmd.load_item) begin
                r_func  <= i_func;
                r_addr  <= i_address;
                r_ilen  <= i_length;
                r_iloop <= i_loop;
                r_iuniq <= i_unique;
                r_istep <= i_step;
                r_igain <= i_gain;
            end
            if (i_cmd.scan_start) begin
                r_v <= '0;
                r_dup <= 1'b0;
                r_freef <= 1'b0;
                r_stopf <= 1'b0;
                r_free <= '0;
                r_stopv <= '0;
                r_acc <= '0;
            end
            if (i_cmd.scan_step) begin
                r_v <= r_v + 1'b1;
                if (w_hit) begin
                    r_dup <= 1'b1;
                    if (!r_stopf) begin
                        r_stopf <= 1'b1;
                        r_stopv <= w_vi;
                    end
                end
                if (!w_act && !r_freef) begin
                    r_freef <= 1'b1;
                    r_free <= w_vi;
                end
            end
            if (i_cmd.rd2) begin
                r_s1 <= r_phase ? r_rd[31:16] : r_rd[15:0];
            end
            if (i_cmd.mul1) begin
                r_s2 <= r_phase ? r_rd[31:16] : r_rd[15:0];
                r_gsq <= r_gn[w_vi] * r_gn[w_vi];
            end
            if (i_cmd.mul2) begin
                r_interp <= w_s1x * w_fa + w_s2x * w_fb;
            end
            if (i_cmd.acc) begin
                r_prod <= r_interp * $signed({1'b0, r_gsq});
            end
            if (i_cmd.voice_update) begin
                if (w_accs > (ACC_W+1)'(LIM)) r_acc <= LIM;
                else if (w_accs < -(ACC_W+1)'(LIM)) r_acc <= -LIM;
                else r_acc <= ACC_W'(w_accs);
                r_pos[w_vi] <= w_npos;
                if ({1'b0, w_npos[POS_W-1:8]} + 14'd1 >= {1'b0, r_len[w_vi]}) begin
                    if (r_lp[w_vi]) r_pos[w_vi] <= '0;
                    else r_active[w_vi] <= 1'b0;
                end
                r_v <= r_v + 1'b1;
            end
            if (i_cmd.play_commit && r_freef && !(r_dup && r_iuniq)) begin
                r_active[r_free] <= 1'b1;
                r_base[r_free] <= r_addr;
                r_len[r_free] <= r_ilen;
                r_pos[r_free] <= '0;
                r_lp[r_free] <= r_iloop;
                r_stp[r_free] <= r_istep;
                r_gn[r_free] <= r_igain;
            end
            if (i_cmd.stop_commit && r_stopf) begin
                r_active[r_stopv] <= 1'b0;
                r_pos[r_stopv] <= '0;
            end
            if (i_cmd.do_round) begin
                r_round <= 17'((w_mag + (ACC_W'(1) <<< (ACC_SHIFT-1))) >>> ACC_SHIFT);
            end
            if (i_cmd.out_load) begin
                o_mixed <= '0;
                o_right_side <= 1'b0;
                o_accepted <= 1'b0;
                o_vidx <= '0;
                unique case (r_func)
                    FUNC_PLAY: if (r_freef && !(r_dup && r_iuniq)) begin
                        o_accepted <= 1'b1;
                        o_vidx <= 4'(r_free);
                    end
                    FUNC_STOP: if (r_stopf) o_vidx <= 4'(r_stopv);
                    FUNC_TICK: begin
                        o_mixed <= r_acc[ACC_W-1] ? -r_round[15:0] : r_round[15:0];
                        o_right_side <= r_phase;
                        r_phase <= ~r_phase;
                    end
                    default: ;
                endcase
            end
        end
    end
endmodule

FILE: rtl/wavetable_voice_mixer.sv
// Write goes straight to the result; play and stop scan every voice, and tick also
// reads two frames, interpolates and mixes each active voice.
// One request at a time: the next request is taken in the same cycle as the result
// is taken, or once no result waits; the walk over the single frame read port sets the pace.
// Reset (i_rst_n low, synchronous) frees all voices and sets the next tick to left.
// Frame memory is not cleared.
module wavetable_voice_mixer #(
    parameter int VOICES      = 16,
    parameter int FRAME_DEPTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // func[1:0], address[13:2], left[29:14], right[45:30], length[58:46],
    // loop[59], unique[60], pitch_step[76:61], volume[92:77]
    input  logic [95:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // mixed_sample[15:0], play_accepted[16], voice_index[20:17]
    output logic [23:0] m_axis_tdata,
    // right_side[0]
    output logic        m_axis_tuser
);
    import wvm_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    logic [15:0] w_mixed;
    logic        w_acc;
    logic [3:0]  w_vidx;

    wvm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_axis_tvalid), .o_s_tready(s_axis_tready),
        .o_m_tvalid(m_axis_tvalid), .i_m_tready(m_axis_tready),
        .i_status(w_status), .o_cmd(w_cmd)
    );

    wvm_datapath #(.VOICES(VOICES), .FRAME_DEPTH(FRAME_DEPTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_func(s_axis_tdata[1:0]), .i_address(s_axis_tdata[13:2]),
        .i_left(s_axis_tdata[29:14]), .i_right(s_axis_tdata[45:30]),
        .i_length(s_axis_tdata[58:46]), .i_loop(s_axis_tdata[59]),
        .i_unique(s_axis_tdata[60]), .i_step(s_axis_tdata[76:61]),
        .i_gain(s_axis_tdata[92:77]),
        .i_cmd(w_cmd), .o_status(w_status),
        .o_mixed(w_mixed), .o_right_side(m_axis_tuser),
        .o_accepted(w_acc), .o_vidx(w_vidx)
    );

    assign m_axis_tdata = {3'b0, w_vidx, w_acc, w_mixed};
endmodule

FILE: tb/tb_wavetable_voice_mixer.sv
module tb_wavetable_voice_mixer;
    timeunit 1ns;
    timeprecision 1ps;
    import wvm_pkg::*;

    localparam int NV = 16;
    localparam int DEPTH = 4096;
    localparam longint LIM = 64'sd32767 * (64'sd1 <<< 38);

    typedef struct packed {
        logic [15:0] volume;
        logic [15:0] step;
        logic        uniq;
        logic        lp;
        logic [12:0] len;
        logic [15:0] right;
        logic [15:0] left;
        logic [11:0] addr;
        t_func       func;
    } t_req;

    typedef struct packed {
        logic [15:0] mixed;
        logic        right_side;
        logic        accepted;
        logic [3:0]  vidx;
    } t_mix_out;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic m_axis_tuser;

    logic [31:0] frames [DEPTH];
    bit          written [DEPTH];
    bit          v_on [NV];
    logic [11:0] v_base [NV];
    logic [12:0] v_len [NV];
    logic [20:0] v_pos [NV];
    logic [15:0] v_step [NV];
    logic [15:0] v_gain [NV];
    bit          v_loop [NV];
    bit          phase;

    t_mix_out expected_mix [$];
    int mismatches = 0;
    int n_sent = 0, n_ticks = 0, n_plays = 0, n_checked = 0;
    bit hold_off = 0;
    bit no_idle = 0;

    always #2 i_clk = ~i_clk;

    wavetable_voice_mixer i_dut (.*);

    function automatic longint half_at(logic [11:0] a, bit r);
        logic [31:0] w;
        w = frames[a];
        return r ? longint'($signed(w[31:16])) : longint'($signed(w[15:0]));
    endfunction

    function automatic t_mix_out predict_mix(t_req q);
        t_mix_out o;
        bit found;
        longint acc, s1, s2, interp, m;
        longint unsigned gsq, p;
        logic [11:0] i;
        o = '0;
        case (q.func)
            FUNC_WRITE: begin
                frames[q.addr] = {q.right, q.left};
                written[q.addr] = 1;
            end
            FUNC_PLAY: begin
                found = 0;
                for (int v = 0; v < NV; v++)
                    if (v_on[v] && v_base[v] == q.addr) found = 1;
                if (!found || !q.uniq) begin
                    for (int v = 0; v < NV; v++) begin
                        if (!v_on[v]) begin
                            v_on[v] = 1; v_base[v] = q.addr; v_len[v] = q.len;
                            v_pos[v] = '0; v_loop[v] = q.lp; v_step[v] = q.step;
                            v_gain[v] = q.volume;
                            o.accepted = 1; o.vidx = 4'(v);
                            break;
                        end
                    end
                end
            end
            FUNC_STOP: begin
                for (int v = 0; v < NV; v++) begin
                    if (v_on[v] && v_base[v] == q.addr) begin
                        v_on[v] = 0; v_pos[v] = '0; o.vidx = 4'(v);
                        break;
                    end
                end
            end
            default: begin
                acc = 0;
                o.right_side = phase;
                for (int v = 0; v < NV; v++) begin
                    if (!v_on[v]) continue;
                    p = v_pos[v];
                    i = v_base[v] + 12'(p >> 8);
                    s1 = half_at(i, phase);
                    s2 = half_at(i + 12'd1, phase);
                    interp = s1 * (256 - longint'(p & 255)) + s2 * longint'(p & 255);
                    gsq = longint'(v_gain[v]) * longint'(v_gain[v]);
                    acc += interp * longint'(gsq);
                    if (acc > LIM) acc = LIM;
                    if (acc < -LIM) acc = -LIM;
                    if (phase) begin
                        p += v_step[v];
                        if (p > 64'h1FFFFF) p = 64'h1FFFFF;
                        v_pos[v] = 21'(p);
                    end
                    if ((p >> 8) + 1 >= v_len[v]) begin
                        if (v_loop[v]) v_pos[v] = '0;
                        else v_on[v] = 0;
                    end
                end
                m = acc < 0 ? -((-acc + (64'sd1 <<< 37)) >>> 38)
                            : ((acc + (64'sd1 <<< 37)) >>> 38);
                o.mixed = m[15:0];
                phase ^= 1;
            end
        endcase
        return o;
    endfunction

    // a play must only reach frames already written
    function automatic bit sound_ready(logic [11:0] a, logic [12:0] len);
        int n;
        n = (len < 2) ? 2 : len + 1;
        for (int k = 0; k < n; k++)
            if (!written[12'(a + k)]) return 0;
        return 1;
    endfunction

    task automatic send_request(t_req q);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata <= {3'b0, q};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_mix.push_back(predict_mix(q));
        n_sent++;
        if (q.func == FUNC_TICK) n_ticks++;
        if (q.func == FUNC_PLAY) n_plays++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                t_mix_out got, exp_o;
                got = '0;
                got.mixed = m_axis_tdata[15:0];
                got.accepted = m_axis_tdata[16];
                got.vidx = m_axis_tdata[20:17];
                got.right_side = m_axis_tuser;
                n_checked++;
                if (expected_mix.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h", got);
                end else begin
                    exp_o = expected_mix.pop_front();
                    if (got !== exp_o) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp mix %0d r %0b acc %0b v %0d,",
                                      " got mix %0d r %0b acc %0b v %0d"},
                                $signed(exp_o.mixed), exp_o.right_side,
                                exp_o.accepted, exp_o.vidx,
                                $signed(got.mixed), got.right_side,
                                got.accepted, got.vidx);
                    end
                end
            end
        end
    end

    // receiver stalls
    initial begin
        int s;
        forever begin
            @(posedge i_clk);
            if (hold_off) m_axis_tready <= 1'b0;
            else if (no_idle) m_axis_tready <= 1'b1;
            else begin
                s = $urandom_range(0, 15);
                if (s > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (s) @(posedge i_clk);
                end
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic write_frame(logic [11:0] a, logic [15:0] l, logic [15:0] r);
        t_req q;
        q = '0; q.func = FUNC_WRITE; q.addr = a; q.left = l; q.right = r;
        send_request(q);
    endtask

    task automatic play(logic [11:0] a, logic [12:0] len, bit lp, bit u,
                        logic [15:0] st, logic [15:0] vol);
        t_req q;
        q = '0; q.func = FUNC_PLAY; q.addr = a; q.len = len; q.lp = lp; q.uniq = u;
        q.step = st; q.volume = vol;
        q.left = 16'($urandom); q.right = 16'($urandom);
        send_request(q);
    endtask

    task automatic stop(logic [11:0] a);
        t_req q;
        q = '0; q.func = FUNC_STOP; q.addr = a; q.left = 16'($urandom);
        send_request(q);
    endtask

    task automatic tick();
        t_req q;
        q = '0; q.func = FUNC_TICK; q.addr = 12'($urandom); q.len = 13'($urandom);
        send_request(q);
    endtask

    task automatic test_directed();
        for (int k = 0; k < 8; k++)
            write_frame(12'(k), (k % 2) ? 16'h7FFF : 16'h8000,
                        (k % 2) ? 16'h8000 : 16'h7FFF);
        write_frame(12'hFFF, 16'h7FFF, 16'h7FFF);
        play(12'd0, 13'd4, 1'b1, 1'b0, 16'd128, 16'd32768);
        play(12'd0, 13'd4, 1'b0, 1'b1, 16'd256, 16'd32768);
        play(12'hFFF, 13'd1, 1'b0, 1'b0, 16'hFFFF, 16'hFFFF);
        play(12'd2, 13'd0, 1'b0, 1'b0, 16'd0, 16'd0);
        play(12'd1, 13'd6, 1'b0, 1'b0, 16'hFFFF, 16'd20000);
        repeat (6) tick();
        stop(12'd0);
        stop(12'd0);
        stop(12'd77);
    endtask

    task automatic test_voices_full();
        for (int k = 0; k < 17; k++) play(12'd3, 13'd4, 1'b1, 1'b0, 16'd300, 16'd40000);
        repeat (3) tick();
        for (int k = 0; k < 17; k++) stop(12'd3);
    endtask

    task automatic test_random(int n_items);
        t_req q;
        int c;
        for (int k = 0; k < n_items; k++) begin
            q = '0;
            q.left = 16'($urandom); q.right = 16'($urandom); q.step = 16'($urandom);
            q.volume = 16'($urandom); q.len = 13'($urandom);
            q.lp = 1'($urandom); q.uniq = 1'($urandom);
            c = $urandom_range(0, 99);
            if (c < 15) begin
                q.func = FUNC_WRITE;
                q.addr = ($urandom_range(0, 3) == 0) ? 12'($urandom)
                                                      : 12'($urandom_range(0, 63));
            end else if (c < 30) begin
                q.func = FUNC_PLAY;
                q.addr = 12'($urandom_range(0, 40));
                q.len = ($urandom_range(0, 9) == 0) ? 13'($urandom_range(0, 8191))
                                                   : 13'($urandom_range(0, 20));
                if ($urandom_range(0, 3) != 0) q.step = 16'($urandom_range(0, 600));
                if ($urandom_range(0, 9) == 0) q.volume = 16'd32768;
                if (!sound_ready(q.addr, q.len)) q.func = FUNC_TICK;
            end else if (c < 38) begin
                q.func = FUNC_STOP;
                q.addr = 12'($urandom_range(0, 40));
            end else begin
                q.func = FUNC_TICK;
                q.addr = 12'($urandom);
            end
            send_request(q);
        end
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_off = 1;
                repeat (600) @(posedge i_clk);
                hold_off = 0;
            end
            begin
                no_idle = 1;
                for (int k = 0; k < 20; k++) tick();
                no_idle = 0;
            end
        join
    endtask

    task automatic test_no_idle();
        no_idle = 1;
        test_random(200);
        no_idle = 0;
    endtask

    initial begin
        int w;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int k = 0; k < 64; k++) write_frame(12'(k), 16'($urandom), 16'($urandom));
        test_directed();
        test_voices_full();
        test_backpressure();
        test_random(1650);
        test_no_idle();
        s_axis_tvalid <= 1'b0;
        w = 0;
        while (expected_mix.size() != 0 && w < 200000) begin
            @(posedge i_clk);
            w++;
        end
        repeat (200) @(posedge i_clk);
        $display("Sent %0d requests (%0d ticks, %0d plays), checked %0d results.",
                 n_sent, n_ticks, n_plays, n_checked);
        $display("Mismatches: %0d, pending: %0d", mismatches, expected_mix.size());
        if (mismatches == 0 && expected_mix.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #8ms;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
